// ----- rtl/core/ffpra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpra_pkg
// Shared types, codes and constants of the first-fit page-run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpra_pkg;

    // field widths
    localparam int FRAME_W     = 32;
    localparam int LEN_W       = 11;
    localparam int USABLE_W    = 11;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // bitmap word geometry
    localparam int PAGE_WORD_W = 32;
    localparam int WSEL_W      = 5;

    // register reset values
    localparam logic [FRAME_W-1:0]  BASE_FRAME_RST   = '0;
    localparam logic [USABLE_W-1:0] USABLE_PAGES_RST = 11'd1024;

    // request operation codes
    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NOROOM  = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_FRAME   = 1'b0,
        CFG_USABLE_PAGES = 1'b1
    } t_cfg_idx;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    clr_write;
        logic    check;
        logic    walk_init;
        logic    walk_from_lo;
        logic    walk;
        logic    scan_eval;
        logic    set_end;
        logic    upd_eval;
        logic    out_load;
        t_status res_status;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic zero_len;
        logic is_free;
        logic too_long;
        logic free_bad;
        logic ev_vld;
        logic hit;
        logic last_word;
        logic upd_end;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/ffpra_req_if.sv -----
// ----------------------------------------------------------------------------
// ffpra_req_if
// Request channel: allocate or free a run of pages.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffpra_req_if;

    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [ffpra_pkg::FRAME_W-1:0]   page_frame;
    logic [ffpra_pkg::LEN_W-1:0]     run_length;

    modport source (
        output valid,
        output operation,
        output page_frame,
        output run_length,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  page_frame,
        input  run_length,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/ffpra_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ffpra_rsp_if
// Response channel: first frame of an allocated run and a status code.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffpra_rsp_if;

    logic                            valid;
    logic                            ready;
    logic [ffpra_pkg::FRAME_W-1:0]   first_frame;
    logic [ffpra_pkg::STATUS_W-1:0]  status;

    modport source (
        output valid,
        output first_frame,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_frame,
        input  status,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/ffpra_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffpra_ctrl
// Sequencer of the allocator: clearing pass, request check, first-fit scan,
// bitmap update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpra_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  ffpra_pkg::t_dp_stat   i_stat,
    output ffpra_pkg::t_ctl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_UPD_START,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    ffpra_pkg::t_status  r_code, n_code;

    // command decode and next state
    always_comb begin
        n_state            = r_state;
        n_code             = r_code;
        o_cmd              = '0;
        o_cmd.res_status   = r_code;
        o_in_ready         = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.zero_len) begin
                    n_code  = ffpra_pkg::ST_OUTSIDE;
                    n_state = S_FINISH;
                end else if (i_stat.is_free) begin
                    if (i_stat.free_bad) begin
                        n_code  = ffpra_pkg::ST_OUTSIDE;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_UPD_START;
                    end
                end else if (i_stat.too_long) begin
                    n_code  = ffpra_pkg::ST_NOROOM;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.walk      = 1'b1;
                o_cmd.scan_eval = 1'b1;
                if (i_stat.ev_vld) begin
                    if (i_stat.hit) begin
                        n_state = S_UPD_START;
                    end else if (i_stat.last_word) begin
                        n_code  = ffpra_pkg::ST_NOROOM;
                        n_state = S_FINISH;
                    end
                end
            end
            S_UPD_START: begin
                o_cmd.walk_init    = 1'b1;
                o_cmd.walk_from_lo = 1'b1;
                o_cmd.set_end      = 1'b1;
                n_state            = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.walk     = 1'b1;
                o_cmd.upd_eval = 1'b1;
                if (i_stat.upd_end) begin
                    n_code  = ffpra_pkg::ST_DONE;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ffpra_pkg::ST_DONE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // a result is only loaded into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded while output register busy");

endmodule

`default_nettype wire

// ----- rtl/core/ffpra_dpath.sv -----
// ----------------------------------------------------------------------------
// ffpra_dpath
// Datapath of the allocator: configuration registers, in-use bitmap memory
// of 32-bit words, per-word first-fit evaluation, run set/clear and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpra_dpath #(
    parameter int NUM_PAGES = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // request payload
    input  wire                                   i_in_operation,
    input  wire  [ffpra_pkg::FRAME_W-1:0]         i_in_page_frame,
    input  wire  [ffpra_pkg::LEN_W-1:0]           i_in_run_length,
    // configuration writes
    input  wire                                   i_cfg_we,
    input  wire  [ffpra_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [ffpra_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // control
    input  ffpra_pkg::t_ctl_cmd                   i_cmd,
    output ffpra_pkg::t_dp_stat                   o_stat,
    // result
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [ffpra_pkg::FRAME_W-1:0]         o_first_frame,
    output logic [ffpra_pkg::STATUS_W-1:0]        o_status
);

    localparam int WW     = ffpra_pkg::PAGE_WORD_W;
    localparam int SW     = ffpra_pkg::WSEL_W;
    localparam int WORDS  = (NUM_PAGES + WW - 1) / WW;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = (AW + SW + 1 > 12) ? AW + SW + 1 : 12;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(WORDS - 1);
    localparam logic [CNT_W-1:0] PAGES_C   = CNT_W'(NUM_PAGES);

    // configuration registers
    logic [ffpra_pkg::FRAME_W-1:0]  r_base;
    logic [ffpra_pkg::USABLE_W-1:0] r_usable;

    // request registers
    logic                           r_op;
    logic [ffpra_pkg::LEN_W-1:0]    r_len;
    logic [ffpra_pkg::FRAME_W-1:0]  r_off;
    logic [CNT_W-1:0]               r_lim;

    // run bounds and scan carry
    logic [CNT_W-1:0]               r_lo, r_hi, r_run;
    logic [AW-1:0]                  r_end_word;

    // word walk
    logic [AW-1:0]                  r_rd_addr, r_ev_addr;
    logic                           r_ev_vld;
    logic [WW-1:0]                  r_rd_data;
    logic [WW-1:0]                  mem [WORDS];

    // output register
    logic                           r_out_vld;
    logic [ffpra_pkg::FRAME_W-1:0]  r_out_frame;
    ffpra_pkg::t_status             r_out_status;

    // combinational
    logic [CNT_W-1:0]               len_c, usable_c, hi_m1;
    logic [CNT_W-1:0]               gidx [WW];
    logic [WW-1:0]                  used, hit_v, mask;
    logic [CNT_W-1:0]               run [WW];
    logic                           scan_hit, any_used;
    logic [CNT_W-1:0]               sel_end, hit_start, carry;
    int                             k_last;
    logic                           mem_we;
    logic [AW-1:0]                  mem_wa;
    logic [WW-1:0]                  mem_wd;
    logic [AW-1:0]                  rd_next;

    assign len_c    = CNT_W'(r_len);
    assign usable_c = CNT_W'(r_usable);
    assign hi_m1    = r_hi - CNT_W'(1);
    assign rd_next  = (r_rd_addr == LAST_ADDR) ? r_rd_addr : r_rd_addr + AW'(1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= ffpra_pkg::BASE_FRAME_RST;
            r_usable <= ffpra_pkg::USABLE_PAGES_RST;
        end else if (i_cfg_we) begin
            case (ffpra_pkg::t_cfg_idx'(i_cfg_idx))
                ffpra_pkg::CFG_BASE_FRAME:   r_base   <= i_cfg_wdata;
                ffpra_pkg::CFG_USABLE_PAGES: r_usable <= i_cfg_wdata[ffpra_pkg::USABLE_W-1:0];
                default: ;
            endcase
        end
    end

    // per-bit page index, in-use view and update mask of the evaluated word
    always_comb begin
        for (int j = 0; j < WW; j++) begin
            gidx[j] = CNT_W'({r_ev_addr, SW'(j)});
            used[j] = r_rd_data[j] | (gidx[j] >= r_lim);
            mask[j] = (gidx[j] >= r_lo) && (gidx[j] < r_hi);
        end
    end

    // free run length ending at each bit, carried across words
    always_comb begin
        any_used = 1'b0;
        k_last   = 0;
        for (int j = 0; j < WW; j++) begin
            any_used = 1'b0;
            k_last   = 0;
            for (int k = 0; k <= j; k++) begin
                if (used[k]) begin
                    any_used = 1'b1;
                    k_last   = k;
                end
            end
            run[j]   = any_used ? CNT_W'(j - k_last) : r_run + CNT_W'(j + 1);
            hit_v[j] = run[j] >= len_c;
        end
    end

    // lowest bit where the run reaches the requested length
    always_comb begin
        scan_hit = 1'b0;
        sel_end  = '0;
        for (int j = WW - 1; j >= 0; j--) begin
            if (hit_v[j]) begin
                scan_hit = 1'b1;
                sel_end  = gidx[j];
            end
        end
        carry     = run[WW-1];
        hit_start = sel_end + CNT_W'(1) - len_c;
    end

    // memory write port: clearing pass or run update
    always_comb begin
        mem_we = i_cmd.clr_write || (i_cmd.upd_eval && r_ev_vld);
        mem_wa = i_cmd.clr_write ? r_rd_addr : r_ev_addr;
        if (i_cmd.clr_write) begin
            mem_wd = '0;
        end else if (r_op == ffpra_pkg::OP_FREE) begin
            mem_wd = r_rd_data & ~mask;
        end else begin
            mem_wd = r_rd_data | mask;
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.walk) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    // walk control and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.walk_init) begin
                r_rd_addr <= i_cmd.walk_from_lo ? r_lo[AW+SW-1:SW] : '0;
                r_ev_vld  <= 1'b0;
            end else if (i_cmd.walk) begin
                r_rd_addr <= rd_next;
                r_ev_vld  <= 1'b1;
            end else if (i_cmd.clr_write) begin
                r_rd_addr <= rd_next;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_operation;
            r_len <= i_in_run_length;
            r_off <= i_in_page_frame - r_base;
            r_lim <= (usable_c > PAGES_C) ? PAGES_C : usable_c;
        end
        if (i_cmd.check) begin
            r_run <= '0;
            r_lo  <= r_off[CNT_W-1:0];
            r_hi  <= r_off[CNT_W-1:0] + len_c;
        end
        if (i_cmd.walk) begin
            r_ev_addr <= r_rd_addr;
        end
        if (i_cmd.scan_eval && r_ev_vld) begin
            if (scan_hit) begin
                r_lo <= hit_start;
                r_hi <= sel_end + CNT_W'(1);
            end else begin
                r_run <= carry;
            end
        end
        if (i_cmd.set_end) begin
            r_end_word <= hi_m1[AW+SW-1:SW];
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.res_status;
            if (i_cmd.res_status == ffpra_pkg::ST_DONE && r_op == ffpra_pkg::OP_ALLOC) begin
                r_out_frame <= r_base + ffpra_pkg::FRAME_W'(r_lo);
            end else begin
                r_out_frame <= '0;
            end
        end
    end

    // status to controller
    always_comb begin
        o_stat            = '0;
        o_stat.clear_done = (r_rd_addr == LAST_ADDR);
        o_stat.zero_len   = (r_len == '0);
        o_stat.is_free    = (r_op == ffpra_pkg::OP_FREE);
        o_stat.too_long   = (len_c > r_lim);
        o_stat.free_bad   = (r_off >= ffpra_pkg::FRAME_W'(r_lim)) ||
                            (({1'b0, r_off} + 33'(r_len)) > 33'(r_lim));
        o_stat.ev_vld     = r_ev_vld;
        o_stat.hit        = scan_hit;
        o_stat.last_word  = (CNT_W'({r_ev_addr, SW'(0)}) + CNT_W'(WW)) >= r_lim;
        o_stat.upd_end    = r_ev_vld && (r_ev_addr == r_end_word);
        o_stat.out_free   = !r_out_vld || i_out_ready;
    end

    assign o_out_valid   = r_out_vld;
    assign o_first_frame = r_out_frame;
    assign o_status      = r_out_status;

    // a found run lies wholly below the usable count
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_eval && r_ev_vld && scan_hit) |-> (hit_start + len_c <= r_lim))
        else $error("first-fit run exceeds usable pages");

    // run updates never write past the last word of the run
    a_upd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd_eval && r_ev_vld) |-> (r_ev_addr <= r_end_word))
        else $error("run update beyond its last word");

    // read address stays inside the bitmap
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_addr <= LAST_ADDR)
        else $error("bitmap read address out of range");

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_page_run_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_unit
// First-fit allocator of contiguous page runs over an in-use bitmap.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       beat payload
//  i_req     in    valid/ready     operation, page_frame, run_length
//  o_rsp     out   valid/ready     first_frame, status
//  i_cfg_*   in    write enable    register index, write data
//
//  One request at a time. Allocate scans the 32-bit bitmap words up to the
//  fit, then updates the words the run spans; free only updates the words
//  the run spans; a zero length or range error skips the bitmap. The bitmap
//  memory port reads one word and writes one word per cycle. After reset a
//  clearing pass writes all NUM_PAGES/32 words (rounded up), one per cycle,
//  before the first request is taken. A stalled response holds the next
//  request in its final step; a new request is taken while a response waits.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_run_allocator_unit #(
    parameter int NUM_PAGES = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    ffpra_req_if.sink                          i_req,
    ffpra_rsp_if.source                        o_rsp,
    input  wire                                i_cfg_we,
    input  wire  [ffpra_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [ffpra_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    ffpra_pkg::t_ctl_cmd  cmd;
    ffpra_pkg::t_dp_stat  stat;
    logic                 in_ready;
    logic                 out_valid;
    logic [ffpra_pkg::FRAME_W-1:0]  out_frame;
    logic [ffpra_pkg::STATUS_W-1:0] out_status;

    // sequencer
    ffpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // bitmap and arithmetic
    ffpra_dpath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_operation  (i_req.operation),
        .i_in_page_frame (i_req.page_frame),
        .i_in_run_length (i_req.run_length),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (out_valid),
        .i_out_ready     (o_rsp.ready),
        .o_first_frame   (out_frame),
        .o_status        (out_status)
    );

    // channel hookup
    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = out_valid;
    assign o_rsp.first_frame = out_frame;
    assign o_rsp.status      = out_status;

endmodule

`default_nettype wire
